### rtl/acs_pkg.sv
// Shared types, constants and helper functions for the chunk emit scheduler.
package acs_pkg;

    localparam int TAIL_SILENT_FRAMES = 4;
    localparam int SR_W               = $clog2(TAIL_SILENT_FRAMES + 1);
    localparam int ENERGY_W           = 24;
    localparam int RATIO_W            = 16;
    localparam int CHUNK_W            = 8;
    localparam int FRAME_IDX_W        = 3;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 24;
    localparam int PROD_W             = ENERGY_W + RATIO_W;

    localparam logic [FRAME_IDX_W-1:0] FRAME_REF_LAST = 3'd3;
    localparam logic [FRAME_IDX_W-1:0] FRAME_IDX_SAT  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_CHUNK = 3'd0,
        REG_INIT_SIZE = 3'd1,
        REG_HOLD_SIZE = 3'd2,
        REG_FLUSH     = 3'd3,
        REG_FLOOR     = 3'd4,
        REG_RATIO     = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_FULL    = 2'd1,
        CAUSE_SILENCE = 2'd2,
        CAUSE_FINAL   = 2'd3
    } cause_t;

    typedef struct packed {
        logic [CHUNK_W-1:0]  max_chunk;
        logic [CHUNK_W-1:0]  init_size;
        logic [CHUNK_W-1:0]  hold_size;
        logic                quiet_flush;
        logic [ENERGY_W-1:0] silence_floor_energy;
        logic [RATIO_W-1:0]  ref_ratio;
    } cfg_t;

    typedef struct packed {
        logic                silent;
        logic [ENERGY_W-1:0] ref_energy;
    } det_t;

    typedef struct packed {
        logic               emit;
        logic [CHUNK_W-1:0] emit_frames;
        cause_t             emit_cause;
        logic               is_first_emit;
        logic               frame_silent;
        logic [CHUNK_W-1:0] chunk_size;
    } res_t;

    function automatic logic [CHUNK_W-1:0] eff_max(input cfg_t c);
        return (c.max_chunk == '0) ? CHUNK_W'(1) : c.max_chunk;
    endfunction

    function automatic logic [CHUNK_W-1:0] eff_first(input cfg_t c);
        logic [CHUNK_W-1:0] f;
        logic [CHUNK_W-1:0] m;
        f = (c.init_size == '0) ? CHUNK_W'(1) : c.init_size;
        m = eff_max(c);
        return (f < m) ? f : m;
    endfunction

    function automatic logic [CHUNK_W-1:0] eff_lead(input cfg_t c);
        logic [CHUNK_W-1:0] f;
        f = eff_first(c);
        return (c.hold_size < f) ? c.hold_size : f;
    endfunction

    function automatic logic [CHUNK_W-1:0] start_size(input cfg_t c);
        return (eff_lead(c) != '0) ? eff_lead(c) : eff_first(c);
    endfunction

endpackage

### rtl/acs_if.sv
// Request channels: frame input and scheduling result output.
interface acs_frame_if
    import acs_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] frame_energy;
    logic                end_of_speech;

    modport source (output valid, frame_energy, end_of_speech, input ready);
    modport sink   (input valid, frame_energy, end_of_speech, output ready);
endinterface

interface acs_result_if
    import acs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               emit;
    logic [CHUNK_W-1:0] emit_frames;
    logic [1:0]         emit_cause;
    logic               is_first_emit;
    logic               frame_silent;
    logic [CHUNK_W-1:0] chunk_size;

    modport source (output valid, emit, emit_frames, emit_cause, is_first_emit,
                    frame_silent, chunk_size, input ready);
    modport sink   (input valid, emit, emit_frames, emit_cause, is_first_emit,
                    frame_silent, chunk_size, output ready);
endinterface

### rtl/acs_cfg.sv
// Configuration register file with write decode.
module acs_cfg
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output cfg_t                  cfg_next,
    output logic                  cfg_hit
);

    cfg_t cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_we)
        begin
            cfg_hit = 1'b1;
            case (cfg_index)
                REG_MAX_CHUNK: cfg_next.max_chunk            = cfg_data[CHUNK_W-1:0];
                REG_INIT_SIZE: cfg_next.init_size            = cfg_data[CHUNK_W-1:0];
                REG_HOLD_SIZE: cfg_next.hold_size            = cfg_data[CHUNK_W-1:0];
                REG_FLUSH:     cfg_next.quiet_flush          = cfg_data[0];
                REG_FLOOR:     cfg_next.silence_floor_energy = cfg_data[ENERGY_W-1:0];
                REG_RATIO:     cfg_next.ref_ratio            = cfg_data[RATIO_W-1:0];
                default:       cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_chunk            <= CHUNK_W'(32);
            cfg_reg.init_size            <= CHUNK_W'(3);
            cfg_reg.hold_size            <= '0;
            cfg_reg.quiet_flush          <= 1'b1;
            cfg_reg.silence_floor_energy <= ENERGY_W'(3136);
            cfg_reg.ref_ratio            <= RATIO_W'(655);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/acs_detect.sv
// Silence classifier: reference energy tracking and threshold compare.
module acs_detect
    import acs_pkg::*;
(
    input  logic [ENERGY_W-1:0]    frame_energy,
    input  logic [FRAME_IDX_W-1:0] frame_index,
    input  logic [ENERGY_W-1:0]    ref_energy,
    input  cfg_t                   cfg,
    output det_t                   det
);

    logic [ENERGY_W-1:0] ref_new;
    logic [PROD_W-1:0]   floor_thr;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   thr;
    logic                use_ref;

    always_comb
    begin
        ref_new = ref_energy;
        // frames one to three lower the reference to their energy when it is zero or larger
        if (frame_index != '0 && frame_index <= FRAME_REF_LAST &&
            (ref_energy == '0 || frame_energy < ref_energy))
        begin
            ref_new = frame_energy;
        end

        floor_thr = PROD_W'({cfg.silence_floor_energy, 8'h00});
        prod      = PROD_W'(cfg.ref_ratio) * PROD_W'(ref_new);
        use_ref   = (ref_new != '0) && (ref_new < cfg.silence_floor_energy);
        thr       = (use_ref && prod > floor_thr) ? prod : floor_thr;

        det.silent     = PROD_W'({frame_energy, 8'h00}) < thr;
        det.ref_energy = ref_new;
    end

endmodule

### rtl/acs_core.sv
// Utterance state, pending counters, chunk sizing and emit decision.
module acs_core
    import acs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [ENERGY_W-1:0] frame_energy,
    input  logic                end_of_speech,
    input  cfg_t                cfg,
    input  cfg_t                cfg_next,
    input  logic                cfg_hit,
    output res_t                res
);

    logic [FRAME_IDX_W-1:0] frame_index_reg, frame_index_next;
    logic [ENERGY_W-1:0]    ref_energy_reg, ref_energy_next;
    logic [SR_W-1:0]        silent_run_reg, silent_run_next;
    logic [CHUNK_W-1:0]     pending_frames_reg, pending_frames_next;
    logic [CHUNK_W-1:0]     pending_sound_reg, pending_sound_next;
    logic [CHUNK_W-1:0]     pending_speech_reg, pending_speech_next;
    logic [CHUNK_W-1:0]     current_chunk_reg, current_chunk_next;
    logic                   speech_sent_reg, speech_sent_next;
    logic                   emitted_once_reg, emitted_once_next;

    det_t                   det;
    logic [CHUNK_W-1:0]     pf_inc, ps_inc, psp_inc;
    logic [CHUNK_W:0]       grow_a, grow_b, grow_n;
    logic [CHUNK_W-1:0]     max_eff;

    acs_detect u_detect (
        .frame_energy (frame_energy),
        .frame_index  (frame_index_reg),
        .ref_energy   (ref_energy_reg),
        .cfg          (cfg),
        .det          (det)
    );

    always_comb
    begin
        frame_index_next    = frame_index_reg;
        ref_energy_next     = ref_energy_reg;
        silent_run_next     = silent_run_reg;
        pending_frames_next = pending_frames_reg;
        pending_sound_next  = pending_sound_reg;
        pending_speech_next = pending_speech_reg;
        current_chunk_next  = current_chunk_reg;
        speech_sent_next    = speech_sent_reg;
        emitted_once_next   = emitted_once_reg;

        res.emit          = 1'b0;
        res.emit_frames   = '0;
        res.emit_cause    = CAUSE_NONE;
        res.is_first_emit = 1'b0;
        res.frame_silent  = det.silent;

        pf_inc  = (pending_frames_reg == '1) ? pending_frames_reg : pending_frames_reg + 1'b1;
        ps_inc  = (pending_sound_reg == '1) ? pending_sound_reg : pending_sound_reg + 1'b1;
        psp_inc = (pending_speech_reg == '1) ? pending_speech_reg : pending_speech_reg + 1'b1;

        max_eff = eff_max(cfg);
        grow_a  = {1'b0, current_chunk_reg} + 1'b1;
        grow_b  = {1'b0, current_chunk_reg} + {2'b00, current_chunk_reg[CHUNK_W-1:1]};
        grow_n  = (grow_a > grow_b) ? grow_a : grow_b;

        if (fire)
        begin
            ref_energy_next = det.ref_energy;
            if (frame_index_reg < FRAME_IDX_SAT)
                frame_index_next = frame_index_reg + 1'b1;

            if (det.silent)
            begin
                if (silent_run_reg < SR_W'(TAIL_SILENT_FRAMES))
                    silent_run_next = silent_run_reg + 1'b1;
            end
            else
            begin
                silent_run_next    = '0;
                pending_sound_next = ps_inc;
                // frame zero never counts as speech
                if (frame_index_reg != '0)
                    pending_speech_next = psp_inc;
            end
            pending_frames_next = pf_inc;

            if (end_of_speech)
            begin
                res.emit            = 1'b1;
                res.emit_frames     = pending_frames_next;
                res.emit_cause      = CAUSE_FINAL;
                res.is_first_emit   = !emitted_once_reg;
                frame_index_next    = '0;
                ref_energy_next     = '0;
                silent_run_next     = '0;
                pending_frames_next = '0;
                pending_sound_next  = '0;
                pending_speech_next = '0;
                current_chunk_next  = start_size(cfg);
                speech_sent_next    = 1'b0;
                emitted_once_next   = 1'b0;
            end
            else if (pending_frames_next >= current_chunk_reg)
            begin
                res.emit          = 1'b1;
                res.emit_frames   = pending_frames_next;
                res.emit_cause    = CAUSE_FULL;
                res.is_first_emit = !emitted_once_reg;
                emitted_once_next = 1'b1;
                // lead hold: keep the size until a chunk has carried speech
                if (eff_lead(cfg) != '0 && !speech_sent_reg)
                begin
                    if (pending_speech_next != '0)
                    begin
                        speech_sent_next   = 1'b1;
                        current_chunk_next = eff_first(cfg);
                    end
                end
                else
                begin
                    current_chunk_next = (grow_n < {1'b0, max_eff}) ?
                                         grow_n[CHUNK_W-1:0] : max_eff;
                end
                pending_frames_next = '0;
                pending_sound_next  = '0;
                pending_speech_next = '0;
            end
            else if (cfg.quiet_flush &&
                     silent_run_next >= SR_W'(TAIL_SILENT_FRAMES) &&
                     pending_sound_next != '0)
            begin
                res.emit            = 1'b1;
                res.emit_frames     = pending_frames_next;
                res.emit_cause      = CAUSE_SILENCE;
                res.is_first_emit   = !emitted_once_reg;
                emitted_once_next   = 1'b1;
                pending_frames_next = '0;
                pending_sound_next  = '0;
                pending_speech_next = '0;
            end
        end
        else if (cfg_hit && frame_index_reg == '0 && pending_frames_reg == '0)
        begin
            // reload the start size before the utterance's first frame
            current_chunk_next = start_size(cfg_next);
        end

        res.chunk_size = current_chunk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg    <= '0;
            ref_energy_reg     <= '0;
            silent_run_reg     <= '0;
            pending_frames_reg <= '0;
            pending_sound_reg  <= '0;
            pending_speech_reg <= '0;
            current_chunk_reg  <= CHUNK_W'(3);
            speech_sent_reg    <= 1'b0;
            emitted_once_reg   <= 1'b0;
        end
        else
        begin
            frame_index_reg    <= frame_index_next;
            ref_energy_reg     <= ref_energy_next;
            silent_run_reg     <= silent_run_next;
            pending_frames_reg <= pending_frames_next;
            pending_sound_reg  <= pending_sound_next;
            pending_speech_reg <= pending_speech_next;
            current_chunk_reg  <= current_chunk_next;
            speech_sent_reg    <= speech_sent_next;
            emitted_once_reg   <= emitted_once_next;
        end
    end

endmodule

### rtl/audio_chunk_emit_scheduler.sv
// Chunk emit scheduler for a streamed speech generator.
//
// Usage: each request on frame_in carries one generated frame's squared energy
// (unsigned Q16.8) and an end-of-speech flag. Each frame yields exactly one
// request on result_out: whether pending frames are released now, how many,
// why, whether it is the utterance's first release, whether the frame was
// classified silent, and the chunk size in force afterwards.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
// only while no frame is in flight. Indexes beyond the register list are ignored.
// Pipeline: an accepted frame sits in the input register and its result is
// registered in the output register, from which result_out presents it.
// Throughput: one frame per cycle while result_out.ready stays high; the state
// update between the two registers is combinational.
// Reset: all counters clear, the utterance restarts, registers take their
// defaults and both channels come up empty.
// Stall: a valid result holds in the result register while result_out.ready is low; the input
// register still takes one more frame, after which frame_in.ready drops.
module audio_chunk_emit_scheduler
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    acs_frame_if.sink             frame_in,
    acs_result_if.source          result_out
);

    cfg_t                cfg;
    cfg_t                cfg_next;
    logic                cfg_hit;
    res_t                res;

    logic                in_valid_reg;
    logic [ENERGY_W-1:0] in_energy_reg;
    logic                in_eos_reg;
    logic                out_valid_reg;
    res_t                out_reg;
    logic                advance;

    acs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_next  (cfg_next),
        .cfg_hit   (cfg_hit)
    );

    acs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .frame_energy  (in_energy_reg),
        .end_of_speech (in_eos_reg),
        .cfg           (cfg),
        .cfg_next      (cfg_next),
        .cfg_hit       (cfg_hit),
        .res           (res)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign frame_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_in.ready)
                in_valid_reg <= frame_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.ready && frame_in.valid)
        begin
            in_energy_reg <= frame_in.frame_energy;
            in_eos_reg    <= frame_in.end_of_speech;
        end
        if (advance)
            out_reg <= res;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.emit          = out_reg.emit;
    assign result_out.emit_frames   = out_reg.emit_frames;
    assign result_out.emit_cause    = out_reg.emit_cause;
    assign result_out.is_first_emit = out_reg.is_first_emit;
    assign result_out.frame_silent  = out_reg.frame_silent;
    assign result_out.chunk_size    = out_reg.chunk_size;

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.emit |->
            out_reg.emit_frames == '0 && out_reg.emit_cause == CAUSE_NONE &&
            !out_reg.is_first_emit)
        else $error("result without release carries release fields");

    a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.emit |->
            out_reg.emit_cause != CAUSE_NONE && out_reg.emit_frames != '0)
        else $error("release without cause or frames");

    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.chunk_size != '0)
        else $error("chunk size of zero");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_energy_reg))
        else $error("stalled frame dropped from input register");

endmodule
